@@ sv/dlvr_pkg.sv @@
package dlvr_pkg;

  localparam int DW = 48;
  localparam logic [DW-1:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  // Action codes of the input beat.
  localparam logic [2:0] ACT_SENT   = 3'd0;
  localparam logic [2:0] ACT_ACKED  = 3'd1;
  localparam logic [2:0] ACT_LOST   = 3'd2;
  localparam logic [2:0] ACT_APPLIM = 3'd3;
  localparam logic [2:0] ACT_PRUNE  = 3'd4;

  // 8,000,000 bits per byte-second = 15625 << 9.
  localparam int RATE_MULT_W = 14;
  localparam logic [RATE_MULT_W-1:0] RATE_MULT = 14'd15625;
  localparam int RATE_SHIFT = 9;
  localparam int PW = DW + RATE_MULT_W;

  typedef logic [DW-1:0] u48_t;

  typedef struct packed {
    logic        valid;
    u48_t        pkt_num;
    u48_t        send_time;
    logic [15:0] size;
    u48_t        sent_total;
    u48_t        sent_at_prev_ack;
    u48_t        prev_ack_send_time;
    u48_t        prev_ack_time;
    u48_t        acked_at_prev_ack;
    logic        app_limited;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic start;
    u48_t bytes;
    u48_t dt;
  } div_req_t;

  typedef struct packed {
    logic done;
    u48_t rate;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_PREP,
    DV_RUN
  } div_state_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOOK,
    ST_SND_WAIT,
    ST_ACK_START,
    ST_ACK_WAIT,
    ST_PRUNE,
    ST_DONE
  } seq_state_t;

endpackage

@@ sv/dlvr_ram.sv @@
module dlvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/dlvr_div.sv @@
module dlvr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dlvr_pkg::div_req_t  req,
  output dlvr_pkg::div_rsp_t  rsp
);
  import dlvr_pkg::*;

  // Rate = floor(bytes * 8e6 / dt), saturated to 48 bits.
  div_state_t        st_r, st_nxt;
  u48_t              bytes_r, dt_r, rem_r, quo_r, rate_r;
  logic [PW-1:0]     prod_r;
  logic [5:0]        cnt_r;
  logic              done_r;

  logic [DW-1:0]     hi;
  logic              sat;
  logic [DW:0]       trial, diff;
  logic              ge;

  always_comb begin
    hi    = DW'(prod_r[PW-1:DW-RATE_SHIFT]);
    sat   = (hi >= dt_r);
    trial = {rem_r, quo_r[DW-1]};
    ge    = (trial >= {1'b0, dt_r});
    diff  = trial - {1'b0, dt_r};
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (req.start) st_nxt = DV_MUL;
      DV_MUL:  st_nxt = DV_PREP;
      DV_PREP: st_nxt = sat ? DV_IDLE : DV_RUN;
      DV_RUN:  if (cnt_r == 6'(DW - 1)) st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      unique case (st_r)
        DV_IDLE: begin
          if (req.start) begin
            bytes_r <= req.bytes;
            dt_r    <= req.dt;
          end
        end
        DV_MUL: begin
          prod_r <= PW'(bytes_r) * PW'(RATE_MULT);
        end
        DV_PREP: begin
          if (sat) begin
            rate_r <= MAX48;
            done_r <= 1'b1;
          end else begin
            rem_r <= hi;
            quo_r <= {prod_r[DW-RATE_SHIFT-1:0], {RATE_SHIFT{1'b0}}};
            cnt_r <= '0;
          end
        end
        DV_RUN: begin
          rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
          quo_r <= {quo_r[DW-2:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DW - 1)) begin
            rate_r <= {quo_r[DW-2:0], ge};
            done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.rate = rate_r;

endmodule

@@ sv/delivery_rate_sampler_top.sv @@
// Send, app-limited and unknown actions go from dispatch straight to the result; acks
// and losses first read their slot, and a lost, untracked or unsampled ack ends there.
// A sampled ack takes the ack-rate pass of the shared divider, after a send-rate pass
// when its send time is past the snapshot send time. A prune sweeps all TRACKED_SLOTS
// entries of the slot memory, one per cycle.
// Throughput: one beat at a time, set by the divider and the single slot memory.
// Reset: synchronous, active low; afterwards a clearing pass writes every slot memory entry.
module delivery_rate_sampler_top #(
  parameter int TRACKED_SLOTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [47:0] in_event_time_us,
  input  logic [47:0] in_pkt_num,
  input  logic [15:0] in_pkt_bytes,
  input  logic [47:0] in_inflight_bytes,
  input  logic        in_carries_data,
  input  logic [47:0] in_oldest_kept_num,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sample_valid,
  output logic [47:0] out_bandwidth_bps,
  output logic [47:0] out_rtt_us,
  output logic        out_sample_app_limited,
  output logic        out_time_order_error,
  output logic        out_not_tracked
);
  import dlvr_pkg::*;

  // The table is direct mapped on the low bits of the packet number, so the user must
  // keep the slot count a power of two; the block itself does not enforce it.
  localparam int IDXW = $clog2(TRACKED_SLOTS);

  seq_state_t state_r, state_nxt;

  // Latched input beat.
  logic [2:0]  act_r;
  u48_t        time_r, num_r, infl_r, oldest_r;
  logic [15:0] bytes_r;
  logic        data_r;

  // Sampler state.
  u48_t sent_total_r, acked_total_r, sapa_r, pas_r, pat_r, latest_r, ale_r, oldest_slot_r;
  logic alf_r;

  // Sweep counter shared by the clearing pass and the prune pass.
  logic [IDXW:0]   swp_r;
  logic [IDXW-1:0] paddr_r;
  logic            pv_r;

  // Result being built, and the output register.
  u48_t snd_rate_r, res_bw_r, res_rtt_r;
  logic res_ok_r, res_app_r, res_err_r, res_nt_r;
  logic out_valid_r, out_ok_r, out_app_r, out_err_r, out_nt_r;
  u48_t out_bw_r, out_rtt_r;

  // Slot memory ports.
  logic            ram_we, ram_re;
  logic [IDXW-1:0] ram_waddr, ram_raddr;
  slot_t           ram_wdata, rd;
  logic [SLOT_W-1:0] ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Helpers.
  logic [IDXW-1:0] idx;
  u48_t  sent_new, sapa_new, pas_new, pat_new, bw_min;
  logic  hit, load_out, no_sample, backward, snd_gap;
  slot_t new_slot, cleared;

  assign rd  = slot_t'(ram_rdata);
  assign idx = num_r[IDXW-1:0];

  always_comb begin
    sent_new = sent_total_r + {32'd0, bytes_r};
    sapa_new = sapa_r;
    pas_new  = pas_r;
    pat_new  = pat_r;
    if (infl_r == '0) begin
      sapa_new = sent_new;
      pas_new  = time_r;
      pat_new  = time_r;
    end
    new_slot.valid              = 1'b1;
    new_slot.pkt_num            = num_r;
    new_slot.send_time          = time_r;
    new_slot.size               = bytes_r;
    new_slot.sent_total         = sent_new;
    new_slot.sent_at_prev_ack   = sapa_new;
    new_slot.prev_ack_send_time = pas_new;
    new_slot.prev_ack_time      = pat_new;
    new_slot.acked_at_prev_ack  = acked_total_r;
    new_slot.app_limited        = alf_r;
    cleared       = rd;
    cleared.valid = 1'b0;
    hit       = rd.valid && (rd.pkt_num == num_r);
    // A zero snapshot send time ends the ack without a sample.
    no_sample = (rd.prev_ack_send_time == '0);
    backward  = (time_r <= rd.prev_ack_time);
    snd_gap   = (rd.send_time > rd.prev_ack_send_time);
    bw_min    = (snd_rate_r < div_rsp.rate) ? snd_rate_r : div_rsp.rate;
    load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (swp_r[IDXW-1:0] == '1) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (act_r == ACT_ACKED || act_r == ACT_LOST) begin
          state_nxt = ST_LOOK;
        end else if (act_r == ACT_PRUNE) begin
          state_nxt = ST_PRUNE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LOOK: begin
        if (!hit || act_r == ACT_LOST || no_sample || backward) begin
          state_nxt = ST_DONE;
        end else if (snd_gap) begin
          state_nxt = ST_SND_WAIT;
        end else begin
          state_nxt = ST_ACK_START;
        end
      end
      ST_SND_WAIT:  if (div_rsp.done) state_nxt = ST_ACK_START;
      ST_ACK_START: state_nxt = ST_ACK_WAIT;
      ST_ACK_WAIT:  if (div_rsp.done) state_nxt = ST_DONE;
      ST_PRUNE:     if (swp_r[IDXW]) state_nxt = ST_DONE;
      ST_DONE:      if (load_out) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = cleared;
    ram_re    = 1'b0;
    ram_raddr = idx;
    div_req   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = swp_r[IDXW-1:0];
        ram_wdata = '0;
      end
      ST_DISPATCH: begin
        if (act_r == ACT_SENT && data_r && num_r >= oldest_slot_r) begin
          ram_we    = 1'b1;
          ram_wdata = new_slot;
        end
        if (act_r == ACT_ACKED || act_r == ACT_LOST) begin
          ram_re = 1'b1;
        end
      end
      ST_LOOK: begin
        // A hit retires the entry whether acked or lost.
        ram_we = hit;
        if (hit && act_r == ACT_ACKED && !no_sample && !backward && snd_gap) begin
          div_req.start = 1'b1;
          div_req.bytes = rd.sent_total - rd.sent_at_prev_ack;
          div_req.dt    = rd.send_time - rd.prev_ack_send_time;
        end
      end
      ST_ACK_START: begin
        div_req.start = 1'b1;
        div_req.bytes = acked_total_r - rd.acked_at_prev_ack;
        div_req.dt    = time_r - rd.prev_ack_time;
      end
      ST_PRUNE: begin
        ram_re    = !swp_r[IDXW];
        ram_raddr = swp_r[IDXW-1:0];
        ram_waddr = paddr_r;
        ram_we    = pv_r && rd.valid && (rd.pkt_num < oldest_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      swp_r         <= '0;
      pv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      sent_total_r  <= '0;
      acked_total_r <= '0;
      sapa_r        <= '0;
      pas_r         <= '0;
      pat_r         <= '0;
      latest_r      <= '0;
      alf_r         <= 1'b0;
      ale_r         <= '0;
      oldest_slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          swp_r <= (swp_r[IDXW-1:0] == '1) ? '0 : swp_r + 1'b1;
        end
        ST_IDLE: begin
          if (in_valid) begin
            act_r    <= in_action;
            time_r   <= in_event_time_us;
            num_r    <= in_pkt_num;
            bytes_r  <= in_pkt_bytes;
            infl_r   <= in_inflight_bytes;
            data_r   <= in_carries_data;
            oldest_r <= in_oldest_kept_num;
          end
          res_ok_r  <= 1'b0;
          res_bw_r  <= '0;
          res_rtt_r <= '0;
          res_app_r <= 1'b0;
          res_err_r <= 1'b0;
          res_nt_r  <= 1'b0;
        end
        ST_DISPATCH: begin
          if (act_r == ACT_SENT) begin
            latest_r <= num_r;
            if (data_r) begin
              sent_total_r <= sent_new;
              sapa_r       <= sapa_new;
              pas_r        <= pas_new;
              pat_r        <= pat_new;
            end
          end else if (act_r == ACT_APPLIM) begin
            alf_r <= 1'b1;
            ale_r <= latest_r;
          end
          swp_r <= '0;
          pv_r  <= 1'b0;
        end
        ST_LOOK: begin
          snd_rate_r <= MAX48;
          if (!hit) begin
            res_nt_r <= 1'b1;
          end else if (act_r == ACT_ACKED) begin
            acked_total_r <= acked_total_r + {32'd0, rd.size};
            sapa_r        <= rd.sent_total;
            pas_r         <= rd.send_time;
            pat_r         <= time_r;
            if (alf_r && num_r > ale_r) begin
              alf_r <= 1'b0;
            end
            if (!no_sample && backward) begin
              res_err_r <= 1'b1;
            end
          end
        end
        ST_SND_WAIT: begin
          if (div_rsp.done) begin
            snd_rate_r <= div_rsp.rate;
          end
        end
        ST_ACK_WAIT: begin
          if (div_rsp.done) begin
            res_ok_r  <= 1'b1;
            res_bw_r  <= bw_min;
            res_rtt_r <= time_r - rd.send_time;
            res_app_r <= rd.app_limited;
          end
        end
        ST_PRUNE: begin
          // Read of one entry overlaps the write-back of the one before it.
          if (!swp_r[IDXW]) begin
            swp_r   <= swp_r + 1'b1;
            paddr_r <= swp_r[IDXW-1:0];
            pv_r    <= 1'b1;
          end else begin
            pv_r  <= 1'b0;
            swp_r <= '0;
            if (oldest_r > oldest_slot_r) begin
              oldest_slot_r <= oldest_r;
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_ok_r  <= res_ok_r;
            out_bw_r  <= res_bw_r;
            out_rtt_r <= res_rtt_r;
            out_app_r <= res_app_r;
            out_err_r <= res_err_r;
            out_nt_r  <= res_nt_r;
          end
        end
        default: ;
      endcase
    end
  end

  dlvr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TRACKED_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dlvr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // New beats are taken only while the sequencer is idle; a finished result
  // may still sit in the output register at that time.
  assign in_stall               = (state_r != ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_sample_valid       = out_ok_r;
  assign out_bandwidth_bps      = out_bw_r;
  assign out_rtt_us             = out_rtt_r;
  assign out_sample_app_limited = out_app_r;
  assign out_time_order_error   = out_err_r;
  assign out_not_tracked        = out_nt_r;

endmodule

@@ tb/delivery_rate_sampler_top_test.sv @@
`timescale 1ns / 100ps

module delivery_rate_sampler_top_test;
  import dlvr_pkg::*;

  localparam int SLOTS = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BEATS = 730;
  // Action codes outside the defined set; the block must ignore them.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  action;
    u48_t        t;
    u48_t        num;
    logic [15:0] bytes;
    u48_t        inflight;
    logic        data;
    u48_t        oldest;
  } beat_t;

  typedef struct {
    logic sv;
    u48_t bw;
    u48_t rtt;
    logic al;
    logic toe;
    logic nt;
  } sample_t;

  typedef struct {
    beat_t   b;
    logic    typed;
    sample_t e;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [47:0] in_event_time_us;
  logic [47:0] in_pkt_num;
  logic [15:0] in_pkt_bytes;
  logic [47:0] in_inflight_bytes;
  logic        in_carries_data;
  logic [47:0] in_oldest_kept_num;
  logic        out_valid;
  logic        out_stall;
  logic        out_sample_valid;
  logic [47:0] out_bandwidth_bps;
  logic [47:0] out_rtt_us;
  logic        out_sample_app_limited;
  logic        out_time_order_error;
  logic        out_not_tracked;

  delivery_rate_sampler_top #(.TRACKED_SLOTS(SLOTS)) i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_event_time_us       (in_event_time_us),
    .in_pkt_num             (in_pkt_num),
    .in_pkt_bytes           (in_pkt_bytes),
    .in_inflight_bytes      (in_inflight_bytes),
    .in_carries_data        (in_carries_data),
    .in_oldest_kept_num     (in_oldest_kept_num),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sample_valid       (out_sample_valid),
    .out_bandwidth_bps      (out_bandwidth_bps),
    .out_rtt_us             (out_rtt_us),
    .out_sample_app_limited (out_sample_app_limited),
    .out_time_order_error   (out_time_order_error),
    .out_not_tracked        (out_not_tracked)
  );

  // Shadow copy of the sampler state, kept in step with every accepted beat.
  u48_t        sent_sum, acked_sum, snap_sent, snap_send_time, snap_ack_time;
  u48_t        last_sent_num, applim_end, prune_floor;
  logic        applim;
  logic        tr_valid [SLOTS];
  u48_t        tr_num [SLOTS];
  u48_t        tr_send_time [SLOTS];
  logic [15:0] tr_size [SLOTS];
  u48_t        tr_sent_sum [SLOTS];
  u48_t        tr_snap_sent [SLOTS];
  u48_t        tr_snap_send_time [SLOTS];
  u48_t        tr_snap_ack_time [SLOTS];
  u48_t        tr_acked_sum [SLOTS];
  logic        tr_applim [SLOTS];

  sample_t pending_samples[$];
  int      mismatches;
  int      beats_accepted;
  int      cycles;

  // Packet numbers that the random traffic believes are still in flight.
  u48_t    in_flight_nums[$];
  u48_t    next_num;
  u48_t    now_us;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bits per second from bytes over dt microseconds, saturated to 48 bits.
  function automatic u48_t bits_per_sec(u48_t bytes, u48_t dt);
    logic [127:0] q;
    if (dt == '0) return MAX48;
    q = ({80'd0, bytes} * 128'd8000000) / {80'd0, dt};
    return (q > {80'd0, MAX48}) ? MAX48 : q[47:0];
  endfunction

  function automatic sample_t predict_sample(beat_t b);
    sample_t r;
    int      s;
    u48_t    st, snd_rate, rcv_rate;
    r = '{default: '0};
    s = int'(b.num % SLOTS);
    case (b.action)
      ACT_SENT: begin
        last_sent_num = b.num;
        if (b.data) begin
          sent_sum = sent_sum + u48_t'(b.bytes);
          if (b.inflight == '0) begin
            snap_ack_time = b.t;
            snap_sent = sent_sum;
            snap_send_time = b.t;
          end
          if (b.num >= prune_floor) begin
            tr_valid[s] = 1'b1;
            tr_num[s] = b.num;
            tr_send_time[s] = b.t;
            tr_size[s] = b.bytes;
            tr_sent_sum[s] = sent_sum;
            tr_snap_sent[s] = snap_sent;
            tr_snap_send_time[s] = snap_send_time;
            tr_snap_ack_time[s] = snap_ack_time;
            tr_acked_sum[s] = acked_sum;
            tr_applim[s] = applim;
          end
        end
      end
      ACT_ACKED: begin
        if (!(tr_valid[s] && tr_num[s] == b.num)) begin
          r.nt = 1'b1;
        end else begin
          st = tr_send_time[s];
          acked_sum = acked_sum + u48_t'(tr_size[s]);
          snap_sent = tr_sent_sum[s];
          snap_send_time = st;
          snap_ack_time = b.t;
          tr_valid[s] = 1'b0;
          if (applim && b.num > applim_end) applim = 1'b0;
          if (tr_snap_send_time[s] != '0) begin
            snd_rate = MAX48;
            if (st > tr_snap_send_time[s])
              snd_rate = bits_per_sec(tr_sent_sum[s] - tr_snap_sent[s],
                                      st - tr_snap_send_time[s]);
            if (b.t <= tr_snap_ack_time[s]) begin
              r.toe = 1'b1;
            end else begin
              rcv_rate = bits_per_sec(acked_sum - tr_acked_sum[s], b.t - tr_snap_ack_time[s]);
              r.sv = 1'b1;
              r.bw = (snd_rate < rcv_rate) ? snd_rate : rcv_rate;
              r.rtt = b.t - st;
              r.al = tr_applim[s];
            end
          end
        end
      end
      ACT_LOST: begin
        if (tr_valid[s] && tr_num[s] == b.num) tr_valid[s] = 1'b0;
        else r.nt = 1'b1;
      end
      ACT_APPLIM: begin
        applim = 1'b1;
        applim_end = last_sent_num;
      end
      ACT_PRUNE: begin
        for (int i = 0; i < SLOTS; i++)
          if (tr_valid[i] && tr_num[i] < b.oldest) tr_valid[i] = 1'b0;
        if (b.oldest > prune_floor) prune_floor = b.oldest;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, u48_t got, u48_t want);
    $display("mismatch on %s: got %0h, expected %0h (cycle %0d)",
             what, got, want, cycles);
    mismatches++;
  endtask

  // Offers one beat after a random gap and waits for the block to take it.
  task automatic offer_beat(beat_t b, logic typed, sample_t e);
    int      gap;
    sample_t p;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_action = b.action;
    in_event_time_us = b.t;
    in_pkt_num = b.num;
    in_pkt_bytes = b.bytes;
    in_inflight_bytes = b.inflight;
    in_carries_data = b.data;
    in_oldest_kept_num = b.oldest;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    p = predict_sample(b);
    pending_samples.push_back(typed ? e : p);
    beats_accepted++;
  endtask

  function automatic beat_t mk(logic [2:0] a, u48_t t, u48_t num, logic [15:0] bytes,
                               u48_t inflight, logic data, u48_t oldest);
    beat_t b;
    b = '{a, t, num, bytes, inflight, data, oldest};
    return b;
  endfunction

  function automatic u48_t rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // One beat of random traffic. Most of it is well-formed: sends of increasing
  // packet numbers and acks or losses of packets still in flight. The rest is
  // noise that exercises untracked numbers, odd times and ignored actions.
  function automatic beat_t next_random_beat();
    beat_t b;
    int    r, idx;
    b = mk(ACT_SENT, '0, '0, '0, '0, 1'b0, '0);
    r = $urandom_range(0, 99);
    now_us = now_us + u48_t'($urandom_range(1, 3000));
    if (r < 40 || in_flight_nums.size() == 0) begin
      next_num = next_num + u48_t'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 5) : 1);
      b.num = next_num;
      b.t = now_us;
      b.bytes = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1500));
      b.data = ($urandom_range(0, 7) != 0);
      if (in_flight_nums.size() == 0 || $urandom_range(0, 19) == 0) b.inflight = '0;
      else if ($urandom_range(0, 9) == 0) b.inflight = rand48();
      else b.inflight = u48_t'($urandom_range(1, 200000));
      // An occasional send is numbered one table size ahead, on the same slot as next_num.
      if ($urandom_range(0, 29) == 0) b.num = next_num + u48_t'(SLOTS);
      if (b.data) in_flight_nums.push_back(b.num);
    end else if (r < 72) begin
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, in_flight_nums.size() - 1) : 0;
      b.action = ACT_ACKED;
      b.num = in_flight_nums[idx];
      b.t = now_us;
      // Now and then the ack time runs backward or lands before the send.
      if ($urandom_range(0, 19) == 0) b.t = now_us - u48_t'($urandom_range(0, 20000));
      in_flight_nums.delete(idx);
    end else if (r < 80) begin
      idx = $urandom_range(0, in_flight_nums.size() - 1);
      b.action = ACT_LOST;
      b.num = in_flight_nums[idx];
      in_flight_nums.delete(idx);
    end else if (r < 85) begin
      b.action = ACT_APPLIM;
    end else if (r < 87) begin
      b.action = ACT_PRUNE;
      b.oldest = next_num - u48_t'($urandom_range(0, 30));
      while (in_flight_nums.size() > 0 && in_flight_nums[0] < b.oldest)
        in_flight_nums.delete(0);
    end else begin
      b = mk(3'($urandom_range(ACT_ACKED, ACT_SPARE_HI)), rand48(), rand48(),
             16'($urandom), rand48(), 1'($urandom), rand48());
      // Noise never prunes, so the floor stays under the live packet numbers.
      if (b.action == ACT_PRUNE) b.action = ACT_LOST;
    end
    return b;
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering beats, so the block fills up and has to stall its input.
  initial begin
    int   len;
    logic held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (!held && beats_accepted >= 120) begin
        held = 1'b1;
        out_stall = 1'b1;
        for (int c = 0; c < 3000; c++) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 55) begin
        out_stall = 1'b0;
        len = $urandom_range(1, 20);
      end else begin
        out_stall = 1'b1;
        len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      end
      repeat (len) @(negedge clk);
    end
  end

  // Every result beat is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result beat", u48_t'(out_valid), '0);
      end else begin
        e = pending_samples[0];
        pending_samples.delete(0);
        if (out_sample_valid !== e.sv)
          report_mismatch("sample_valid", u48_t'(out_sample_valid), u48_t'(e.sv));
        if (out_bandwidth_bps !== e.bw) report_mismatch("bandwidth_bps", out_bandwidth_bps, e.bw);
        if (out_rtt_us !== e.rtt) report_mismatch("rtt_us", out_rtt_us, e.rtt);
        if (out_sample_app_limited !== e.al)
          report_mismatch("sample_app_limited", u48_t'(out_sample_app_limited), u48_t'(e.al));
        if (out_time_order_error !== e.toe)
          report_mismatch("time_order_error", u48_t'(out_time_order_error), u48_t'(e.toe));
        if (out_not_tracked !== e.nt)
          report_mismatch("not_tracked", u48_t'(out_not_tracked), u48_t'(e.nt));
      end
    end
  end

  // Watchdog. The limit covers the clearing pass, every prune sweep and a
  // sampled ack for each beat under the worst stalls, several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL delivery_rate_sampler_top");
      $finish;
    end
  end

  initial begin
    row_t    rows[$];
    sample_t quiet, untracked;
    beat_t   b;
    int      settle;

    mismatches = 0;
    beats_accepted = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_SENT;
    in_event_time_us = '0;
    in_pkt_num = '0;
    in_pkt_bytes = '0;
    in_inflight_bytes = '0;
    in_carries_data = 1'b0;
    in_oldest_kept_num = '0;
    sent_sum = '0; acked_sum = '0; snap_sent = '0; snap_send_time = '0; snap_ack_time = '0;
    last_sent_num = '0; applim_end = '0; prune_floor = '0; applim = 1'b0;
    for (int i = 0; i < SLOTS; i++) tr_valid[i] = 1'b0;

    quiet = '{default: '0};
    untracked = quiet;
    untracked.nt = 1'b1;

    // Directed beats. Rows whose outcome is plain from the spec carry it typed
    // in; the rest go through the shadow model.
    rows.push_back('{mk(ACT_ACKED, 48'd50, 48'd5, '0, '0, 1'b0, '0), 1'b1, untracked});
    rows.push_back('{mk(ACT_LOST, '0, 48'd5, '0, '0, 1'b0, '0), 1'b1, untracked});
    rows.push_back('{mk(ACT_SPARE_HI, MAX48, MAX48, 16'hFFFF, MAX48, 1'b1, MAX48),
                     1'b1, quiet});
    rows.push_back('{mk(ACT_SPARE_LO, '0, 48'd1, '0, '0, 1'b0, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_SENT, 48'd100, 48'd1, 16'd1000, '0, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_SENT, 48'd200, 48'd2, 16'd1000, 48'd1000, 1'b1, '0), 1'b1, quiet});
    // A send without data only moves the latest packet number.
    rows.push_back('{mk(ACT_SENT, 48'd210, 48'd3, 16'd500, 48'd2000, 1'b0, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd300, 48'd1, '0, '0, 1'b0, '0), 1'b0, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd400, 48'd2, '0, '0, 1'b0, '0), 1'b0, quiet});
    // A snapshot with a zero send time yields no sample.
    rows.push_back('{mk(ACT_SENT, '0, 48'd4, 16'hFFFF, '0, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd500, 48'd4, '0, '0, 1'b0, '0), 1'b0, quiet});
    // Largest send time and in-flight count, then an ack that precedes the send.
    rows.push_back('{mk(ACT_SENT, MAX48, 48'd10, 16'hFFFF, MAX48, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd600, 48'd10, '0, '0, 1'b0, '0), 1'b0, quiet});
    // App-limited phase marks the next packet.
    rows.push_back('{mk(ACT_APPLIM, '0, '0, '0, '0, 1'b0, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_SENT, 48'd700, 48'd11, 16'd1200, 48'd100, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd900, 48'd11, '0, '0, 1'b0, '0), 1'b0, quiet});
    // Two packets sharing one slot: the later one displaces the earlier.
    rows.push_back('{mk(ACT_SENT, 48'd950, 48'd12, 16'd100, 48'd10, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_SENT, 48'd960, 48'd12 + SLOTS, 16'd100, 48'd10, 1'b1, '0),
                     1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd990, 48'd12, '0, '0, 1'b0, '0), 1'b1, untracked});
    rows.push_back('{mk(ACT_ACKED, 48'd990, 48'd12 + SLOTS, '0, '0, 1'b0, '0), 1'b0, quiet});
    // An ack time equal to the snapshot time is out of order.
    rows.push_back('{mk(ACT_SENT, 48'd1000, 48'd13, 16'd64, '0, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd1000, 48'd13, '0, '0, 1'b0, '0), 1'b0, quiet});
    // Prune, then a send under the floor is counted but not stored.
    rows.push_back('{mk(ACT_PRUNE, '0, '0, '0, '0, 1'b0, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_PRUNE, '0, '0, '0, '0, 1'b0, 48'd20), 1'b1, quiet});
    rows.push_back('{mk(ACT_SENT, 48'd1100, 48'd15, 16'd300, 48'd5, 1'b1, '0), 1'b1, quiet});
    rows.push_back('{mk(ACT_ACKED, 48'd1200, 48'd15, '0, '0, 1'b0, '0), 1'b1, untracked});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) offer_beat(rows[i].b, rows[i].typed, rows[i].e);

    // Random traffic starts from a random base so high number bits toggle.
    next_num = (rand48() & 48'h7FFF_FFFF_0000) + 48'd1000;
    now_us = rand48() & 48'h7FFF_FFFF_FFFF;
    for (int n = 0; n < RANDOM_BEATS; n++) offer_beat(next_random_beat(), 1'b0, quiet);

    // Raise the floor to a random value and then to the top, and keep going.
    offer_beat(mk(ACT_PRUNE, '0, '0, '0, '0, 1'b0, rand48()), 1'b0, quiet);
    offer_beat(mk(ACT_PRUNE, '0, '0, '0, '0, 1'b0, MAX48), 1'b0, quiet);
    for (int n = 0; n < 10; n++) begin
      b = next_random_beat();
      offer_beat(b, 1'b0, quiet);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_samples.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0) begin
      $display("PASS delivery_rate_sampler_top");
    end else begin
      $display("FAIL delivery_rate_sampler_top");
    end
    $finish;
  end

endmodule
